### hw/rtl/dagc_pkg.sv
// shared types and constants for the dag edge table cycle guard
// depends on nothing; used by every other file of the block but dagc_ram
package dagc_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int TAG_W         = 16;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD     = 3'd0,
    FN_DEL     = 3'd1,
    FN_HAS     = 3'd2,
    FN_SINK    = 3'd3,
    FN_CAN     = 3'd4,
    FN_CONNECT = 3'd5
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  node_tag_in;
    logic [TAG_W-1:0]  sink_tag_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                answer;
    logic [SLOT_W-1:0]   slot_index;
  } out_item_t;

  // controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_EXEC,
    CMD_SINK,
    CMD_REACH,
    CMD_CONNW,
    CMD_DEL,
    CMD_POST
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              a_found;
    logic              conn_ok;
    logic              scan_done;
    logic              reach_done;
    logic              hit;
    logic              del_done;
  } dp_stat_t;

endpackage

### hw/rtl/dagc_ram.sv
// generic single write port ram with one registered read port
// depends on nothing
module dagc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/dagc_datapath.sv
// datapath: tag store, adjacency rows, tag search, reachability mask, delete sweep
// depends on dagc_pkg and dagc_ram
module dagc_datapath #(
  parameter int MAX_NODES = dagc_pkg::MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dagc_pkg::dp_cmd_t    cmd,
  input  dagc_pkg::in_item_t   in_data,
  output dagc_pkg::dp_stat_t   stat,
  output dagc_pkg::out_item_t  out_data
);
  import dagc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef logic [MAX_NODES-1:0] row_t;

  logic [FUNC_W-1:0] func_r;
  logic [TAG_W-1:0]  ntag_r;
  logic [TAG_W-1:0]  stag_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     scan_addr_r;
  logic              scan_pend_r;
  logic [IW-1:0]     scan_pidx_r;
  logic              a_found_r;
  logic [IW-1:0]     a_slot_r;
  logic              b_found_r;
  logic [IW-1:0]     b_slot_r;
  row_t              mask_r;
  row_t              done_r;
  logic              reach_pend_r;
  logic [CW-1:0]     del_i_r;
  logic              del_wpend_r;
  logic [IW-1:0]     del_widx_r;
  out_item_t         res_r;
  out_item_t         out_r;

  logic [IW-1:0]    raddr;
  logic [IW-1:0]    waddr;
  logic             tag_we;
  logic             edge_we;
  logic [TAG_W-1:0] tag_wdata;
  row_t             edge_wdata;
  logic [TAG_W-1:0] tag_rdata;
  row_t             edge_rdata;

  row_t          valid_row;
  row_t          low_mask;
  row_t          mask_eff;
  row_t          pending;
  row_t          pick;
  row_t          b_bit;
  row_t          drop_row;
  logic [IW-1:0] pick_idx;
  logic          reach_done;
  logic          hit;
  logic          full;
  logic          conn_ok;
  logic [CW-1:0] count_last;
  logic          del_more;
  logic          del_done;
  logic [IW-1:0] del_src;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
    logic [IW+SLOT_W-1:0] w;
    w = (IW + SLOT_W)'(idx);
    return w[SLOT_W-1:0];
  endfunction

  dagc_ram #(.WIDTH(TAG_W), .DEPTH(MAX_NODES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (waddr),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  dagc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (waddr),
    .wdata (edge_wdata),
    .raddr (raddr),
    .rdata (edge_rdata)
  );

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      valid_row[i] = (32'(i) < 32'(count_r));
      low_mask[i]  = (32'(i) < 32'(a_slot_r));
    end
  end

  // one expansion per cycle: merge the row that came back, pick the next unexpanded node
  assign mask_eff   = mask_r | (reach_pend_r ? edge_rdata : '0);
  assign pending    = mask_eff & ~done_r & valid_row;
  assign pick       = pending & (~pending + row_t'(1));
  assign reach_done = (pending == '0);
  assign hit        = mask_eff[a_slot_r];

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | IW'(i);
      end
    end
  end

  assign b_bit    = row_t'(1) << b_slot_r;
  assign drop_row = (edge_rdata & low_mask) | ((edge_rdata >> 1) & ~low_mask);
  assign full     = (count_r == CW'(MAX_NODES));
  assign conn_ok  = (ntag_r != stag_r) && a_found_r && b_found_r;

  // delete sweep: slot i takes slot i below the victim, slot i+1 above it
  assign count_last = count_r - CW'(1);
  assign del_more   = (del_i_r < count_last);
  assign del_done   = !del_more && !del_wpend_r;
  assign del_src    = (del_i_r < CW'(a_slot_r)) ? del_i_r[IW-1:0]
                                                : IW'(del_i_r[IW-1:0] + IW'(1));

  always_comb begin
    raddr      = scan_addr_r[IW-1:0];
    waddr      = count_r[IW-1:0];
    tag_we     = 1'b0;
    edge_we    = 1'b0;
    tag_wdata  = ntag_r;
    edge_wdata = '0;
    unique case (cmd)
      CMD_SCAN: raddr = scan_addr_r[IW-1:0];
      CMD_EXEC: begin
        raddr = a_slot_r;
        if (func_r == FN_ADD && !a_found_r && !full) begin
          tag_we  = 1'b1;
          edge_we = 1'b1;
        end
      end
      CMD_REACH: raddr = reach_done ? a_slot_r : pick_idx;
      CMD_CONNW: begin
        edge_we    = 1'b1;
        waddr      = a_slot_r;
        edge_wdata = edge_rdata | b_bit;
      end
      CMD_DEL: begin
        raddr = del_src;
        if (del_wpend_r) begin
          tag_we     = 1'b1;
          edge_we    = 1'b1;
          waddr      = del_widx_r;
          tag_wdata  = tag_rdata;
          edge_wdata = drop_row;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      scan_pend_r  <= 1'b0;
      reach_pend_r <= 1'b0;
      del_wpend_r  <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          func_r      <= in_data.func;
          ntag_r      <= in_data.node_tag_in;
          stag_r      <= in_data.sink_tag_in;
          scan_addr_r <= '0;
          scan_pend_r <= 1'b0;
          a_found_r   <= 1'b0;
          b_found_r   <= 1'b0;
          a_slot_r    <= '0;
          b_slot_r    <= '0;
        end
        CMD_SCAN: begin
          if (scan_pend_r) begin
            if (tag_rdata == ntag_r && !a_found_r) begin
              a_found_r <= 1'b1;
              a_slot_r  <= scan_pidx_r;
            end
            if (tag_rdata == stag_r && !b_found_r) begin
              b_found_r <= 1'b1;
              b_slot_r  <= scan_pidx_r;
            end
          end
          if (scan_addr_r < count_r) begin
            scan_pend_r <= 1'b1;
            scan_pidx_r <= scan_addr_r[IW-1:0];
            scan_addr_r <= scan_addr_r + CW'(1);
          end else begin
            scan_pend_r <= 1'b0;
          end
        end
        CMD_EXEC: begin
          res_r.status     <= ST_OK;
          res_r.answer     <= 1'b0;
          res_r.slot_index <= '0;
          unique case (func_r)
            FN_ADD: begin
              if (a_found_r) begin
                res_r.status <= ST_BAD;
              end else if (full) begin
                res_r.status <= ST_FULL;
              end else begin
                count_r          <= count_r + CW'(1);
                res_r.slot_index <= to_slot(count_r[IW-1:0]);
              end
            end
            FN_DEL: begin
              if (!a_found_r) begin
                res_r.status <= ST_BAD;
              end else begin
                res_r.slot_index <= to_slot(a_slot_r);
                del_i_r          <= '0;
                del_wpend_r      <= 1'b0;
              end
            end
            FN_HAS: begin
              if (a_found_r) begin
                res_r.answer     <= 1'b1;
                res_r.slot_index <= to_slot(a_slot_r);
              end
            end
            FN_SINK: begin
              if (a_found_r) begin
                res_r.slot_index <= to_slot(a_slot_r);
              end
            end
            FN_CAN, FN_CONNECT: begin
              if (a_found_r) begin
                res_r.slot_index <= to_slot(a_slot_r);
              end
              if (conn_ok) begin
                mask_r       <= b_bit;
                done_r       <= '0;
                reach_pend_r <= 1'b0;
              end else if (func_r == FN_CONNECT) begin
                res_r.status <= ST_BAD;
              end
            end
            default: res_r.status <= ST_BAD;
          endcase
        end
        CMD_SINK: res_r.answer <= (edge_rdata == '0);
        CMD_REACH: begin
          mask_r <= mask_eff;
          if (!reach_done) begin
            done_r       <= done_r | pick;
            reach_pend_r <= 1'b1;
          end else begin
            reach_pend_r <= 1'b0;
            if (func_r == FN_CAN) begin
              res_r.answer <= !hit;
            end else if (hit) begin
              res_r.status <= ST_BAD;
            end
          end
        end
        CMD_DEL: begin
          if (del_more) begin
            del_wpend_r <= 1'b1;
            del_widx_r  <= del_i_r[IW-1:0];
            del_i_r     <= del_i_r + CW'(1);
          end else begin
            del_wpend_r <= 1'b0;
            if (!del_wpend_r) begin
              count_r <= count_last;
            end
          end
        end
        CMD_POST: out_r <= res_r;
        default: ;
      endcase
    end
  end

  assign stat.func       = func_r;
  assign stat.a_found    = a_found_r;
  assign stat.conn_ok    = conn_ok;
  assign stat.scan_done  = (scan_addr_r == count_r) && !scan_pend_r;
  assign stat.reach_done = reach_done;
  assign stat.hit        = hit;
  assign stat.del_done   = del_done;

  assign out_data = out_r;

endmodule

### hw/rtl/dagc_ctrl.sv
// controller: sequences search, execute, sink read, reachability, connect write, delete sweep and result hand-off
// depends on dagc_pkg
module dagc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dagc_pkg::dp_stat_t stat,
  output dagc_pkg::dp_cmd_t  cmd
);
  import dagc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SINK,
    S_REACH,
    S_CONNW,
    S_DEL,
    S_POST
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   load;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd = CMD_EXEC;
        unique case (stat.func)
          FN_DEL:             state_nxt = stat.a_found ? S_DEL : S_POST;
          FN_SINK:            state_nxt = stat.a_found ? S_SINK : S_POST;
          FN_CAN, FN_CONNECT: state_nxt = stat.conn_ok ? S_REACH : S_POST;
          default:            state_nxt = S_POST;
        endcase
      end
      S_SINK: begin
        cmd       = CMD_SINK;
        state_nxt = S_POST;
      end
      S_REACH: begin
        cmd = CMD_REACH;
        if (stat.reach_done) begin
          state_nxt = (stat.func == FN_CONNECT && !stat.hit) ? S_CONNW : S_POST;
        end
      end
      S_CONNW: begin
        cmd       = CMD_CONNW;
        state_nxt = S_POST;
      end
      S_DEL: begin
        cmd = CMD_DEL;
        if (stat.del_done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd       = CMD_POST;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/dag_edge_table_cycle_guard_core.sv
// top level of the dag edge table cycle guard: controller plus datapath
// depends on dagc_pkg, dagc_ctrl, dagc_datapath (and dagc_ram below it)
//
//   channel  ports                          payload
//   input    in_valid / in_ready / in_data  func, node_tag_in, sink_tag_in
//   result   out_valid/out_ready/out_data   status, answer, slot_index
//
// one transaction at a time; add and has node run the tag search and then execute,
// is sink adds one row read, delete adds a row sweep, and can connect / connect
// do the tag search plus one row read per reached node; the rams' single read port
// serializes these reads.
// rst_n is synchronous; after reset the graph is empty with no clearing pass.
// a result waiting on out_ready does not block the next input transaction;
// only the hand-off of the following result waits for the output register.
module dag_edge_table_cycle_guard_core #(
  parameter int MAX_NODES = dagc_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dagc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dagc_pkg::out_item_t out_data
);
  import dagc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dagc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dagc_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
